// ===== rtl/sbm_pkg.sv =====
// Shared constants for the spectrum bar peak-hold meter.
// No dependencies; imported by sbm_front, sbm_back and the top level.
package sbm_pkg;

   localparam int LEN_W      = 11;
   localparam int GRAV_W     = 13;
   localparam int LEVEL_W    = 16;
   localparam int BIN_W      = 16;
   localparam int INDEX_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int RSP_DATA_W = 40;

   localparam logic [LEVEL_W-1:0] Q_ONE       = 16'h8000;
   localparam logic [LEVEL_W-1:0] SPEED_MAX   = 16'hFFFF;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd1638;
   localparam logic [LEVEL_W-1:0] THR_RESET   = 16'd983;
   localparam logic [LEN_W-1:0]   LEN_RESET   = 11'd256;
   localparam logic [GRAV_W-1:0]  GRAV_RESET  = 13'd131;

endpackage

// ===== rtl/sbm_queue.sv =====
// Two-entry command queue between the front and back parts of the meter.
// Depends on nothing beyond its width parameter.
module sbm_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] head
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sbm_front.sv =====
// Front part: accepts bins, sums them per bar, tracks frame position and
// queues bar and end-of-frame commands. Uses sbm_pkg.
module sbm_front
   import sbm_pkg::*;
#(
   parameter int BARS    = 16,
   parameter int LEN_MAX = 1024,
   parameter int BP_W    = 5,
   parameter int P_W     = 7,
   parameter int SUM_W   = 23,
   parameter int FP_W    = 10,
   parameter int CMD_W   = 42
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [BIN_W-1:0] bin_value,
   input  logic [LEN_W-1:0] spectrum_length,
   output logic             cmd_push,
   output logic [CMD_W-1:0] cmd_data,
   input  logic             cmd_full
);

   typedef struct packed {
      logic             bar_valid;
      logic             frame_end;
      logic [BP_W-1:0]  bar_idx;
      logic [BP_W-1:0]  fill_from;
      logic [P_W-1:0]   group;
      logic [SUM_W-1:0] sum;
   } cmd_type;

   localparam int L2      = (BARS > 1) ? $clog2(BARS) : 0;
   localparam int K       = LEN_W + L2;
   localparam int RECIP_W = LEN_W + 2;
   localparam int PROD_W  = LEN_W + RECIP_W;
   localparam int RECIP   = ((1 << K) + BARS - 1) / BARS;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [P_W-1:0]    bins_ff, bins_in;
   logic [BP_W-1:0]   bar_pos_ff, bar_pos_in;
   logic [FP_W-1:0]   frame_pos_ff, frame_pos_in;

   logic [LEN_W-1:0]  len_eff;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] quot;
   logic [P_W-1:0]    group;
   logic [SUM_W-1:0]  sum_add;
   logic [P_W-1:0]    bins_add;
   logic [LEN_W:0]    fp_next;
   logic              accept;
   cmd_type           cmd;

   assign req_tready = ~cmd_full;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      if (spectrum_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (spectrum_length > LEN_W'(LEN_MAX)) begin
         len_eff = LEN_W'(LEN_MAX);
      end else begin
         len_eff = spectrum_length;
      end
   end

   assign prod  = PROD_W'(len_eff) * PROD_W'(RECIP);
   assign quot  = prod >> K;
   assign group = (quot == '0) ? P_W'(1) : quot[P_W-1:0];

   assign sum_add  = sum_ff + SUM_W'(bin_value);
   assign bins_add = bins_ff + P_W'(1);
   assign fp_next  = (LEN_W+1)'(frame_pos_ff) + (LEN_W+1)'(1);

   always_comb begin
      sum_in       = sum_ff;
      bins_in      = bins_ff;
      bar_pos_in   = bar_pos_ff;
      frame_pos_in = frame_pos_ff;
      cmd          = '0;
      cmd.group    = group;
      cmd.sum      = sum_add;
      cmd.bar_idx  = bar_pos_ff;
      if (accept) begin
         if (bar_pos_ff < BP_W'(BARS)) begin
            sum_in  = sum_add;
            bins_in = bins_add;
            if (bins_add >= group) begin
               cmd.bar_valid = 1'b1;
               bar_pos_in    = bar_pos_ff + BP_W'(1);
               sum_in        = '0;
               bins_in       = '0;
            end
         end
         cmd.fill_from = bar_pos_in;
         if (fp_next >= (LEN_W+1)'(len_eff)) begin
            cmd.frame_end = 1'b1;
            sum_in        = '0;
            bins_in       = '0;
            bar_pos_in    = '0;
            frame_pos_in  = '0;
         end else begin
            frame_pos_in = fp_next[FP_W-1:0];
         end
      end
   end

   assign cmd_push = accept & (cmd.bar_valid | cmd.frame_end);
   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         bins_ff      <= '0;
         bar_pos_ff   <= '0;
         frame_pos_ff <= '0;
      end else begin
         sum_ff       <= sum_in;
         bins_ff      <= bins_in;
         bar_pos_ff   <= bar_pos_in;
         frame_pos_ff <= frame_pos_in;
      end
   end

endmodule

// ===== rtl/sbm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bar average.
// Uses no package items.
module sbm_div #(
   parameter int SUM_W = 23,
   parameter int P_W   = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [P_W-1:0]   divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [P_W-1:0]   rem_ff, rem_in;
   logic [P_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [P_W:0]     trial;
   logic [P_W:0]     diff;
   logic             take;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign take  = (trial >= {1'b0, div_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? diff[P_W-1:0] : trial[P_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/sbm_back.sv =====
// Back part: divides, clamps, updates peak, fall speed and shown height per
// bar, fills missing bars at frame end. Uses sbm_pkg and sbm_div.
module sbm_back
   import sbm_pkg::*;
#(
   parameter int BARS  = 16,
   parameter int BP_W  = 5,
   parameter int P_W   = 7,
   parameter int SUM_W = 23,
   parameter int CMD_W = 42
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  logic [CMD_W-1:0]      cmd_head,
   output logic                  cmd_pop,
   input  logic [GRAV_W-1:0]     gravity_step,
   input  logic [LEVEL_W-1:0]    floor_level,
   input  logic [LEVEL_W-1:0]    change_threshold,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   typedef struct packed {
      logic             bar_valid;
      logic             frame_end;
      logic [BP_W-1:0]  bar_idx;
      logic [BP_W-1:0]  fill_from;
      logic [P_W-1:0]   group;
      logic [SUM_W-1:0] sum;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV    = 5'b00010,
      ST_READ   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_NEXT   = 5'b10000
   } state_type;

   localparam int BAR_W = (BARS > 1) ? $clog2(BARS) : 1;
   localparam int ENT_W = 3 * LEVEL_W;

   cmd_type              head;
   state_type            state_ff, state_in;
   logic [BP_W-1:0]      bar_ff, bar_in;
   logic [BP_W-1:0]      next_bar_ff, next_bar_in;
   logic                 end_ff, end_in;
   logic [LEVEL_W-1:0]   height_ff, height_in;
   logic                 any_ff, any_in;
   logic [BARS-1:0]      valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BP_W-1:0]      rsp_bar_ff, rsp_bar_in;
   logic [LEVEL_W-1:0]   rsp_height_ff, rsp_height_in;
   logic [LEVEL_W-1:0]   rsp_peak_ff, rsp_peak_in;
   logic                 rsp_redraw_ff, rsp_redraw_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_frame_ff, rsp_frame_in;

   logic [ENT_W-1:0]     bar_mem [BARS];
   logic [ENT_W-1:0]     rd_data_ff;
   logic                 rd_valid_ff;
   logic [BAR_W-1:0]     idx;
   logic                 mem_we;

   logic                 div_start;
   logic                 div_done;
   logic [SUM_W-1:0]     div_quo;
   logic [SUM_W-1:0]     floor_wide;
   logic [SUM_W-1:0]     avg_low;
   logic [LEVEL_W-1:0]   avg_h;
   logic [LEVEL_W-1:0]   fill_h;

   logic [LEVEL_W-1:0]   pk, sp, sh;
   logic [LEVEL_W:0]     speed_sum;
   logic [LEVEL_W-1:0]   speed_sat;
   logic [LEVEL_W+1:0]   drop;
   logic [LEVEL_W-1:0]   new_peak, new_speed, new_shown;
   logic [LEVEL_W-1:0]   delta;
   logic                 redraw;
   logic                 is_last;
   logic                 out_free;
   logic [31:0]          bar_ext;

   assign head = cmd_head;
   assign idx  = bar_ff[BAR_W-1:0];

   sbm_div #(
      .SUM_W (SUM_W),
      .P_W   (P_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head.sum),
      .divisor  (head.group),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign cmd_pop   = (state_ff == ST_IDLE) & cmd_valid;
   assign div_start = cmd_pop & head.bar_valid;

   assign floor_wide = SUM_W'(floor_level);
   assign avg_low    = (div_quo < floor_wide) ? floor_wide : div_quo;
   assign avg_h      = (avg_low > SUM_W'(Q_ONE)) ? Q_ONE : avg_low[LEVEL_W-1:0];
   assign fill_h     = (floor_level > Q_ONE) ? Q_ONE : floor_level;

   always_comb begin
      pk = rd_valid_ff ? rd_data_ff[LEVEL_W-1:0]           : LEVEL_RESET;
      sp = rd_valid_ff ? rd_data_ff[2*LEVEL_W-1:LEVEL_W]   : '0;
      sh = rd_valid_ff ? rd_data_ff[ENT_W-1:2*LEVEL_W]     : LEVEL_RESET;
      speed_sum = (LEVEL_W+1)'(sp) + (LEVEL_W+1)'(gravity_step);
      speed_sat = speed_sum[LEVEL_W] ? SPEED_MAX : speed_sum[LEVEL_W-1:0];
      drop      = (LEVEL_W+2)'(pk) - (LEVEL_W+2)'(speed_sat);
      if (height_ff >= pk) begin
         new_peak  = height_ff;
         new_speed = '0;
      end else if ($signed(drop) < $signed((LEVEL_W+2)'(height_ff))) begin
         new_peak  = height_ff;
         new_speed = '0;
      end else begin
         new_peak  = drop[LEVEL_W-1:0];
         new_speed = speed_sat;
      end
      delta     = (height_ff > sh) ? (height_ff - sh) : (sh - height_ff);
      redraw    = (delta > change_threshold);
      new_shown = redraw ? height_ff : sh;
   end

   assign is_last  = (bar_ff == BP_W'(BARS - 1));
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in      = state_ff;
      bar_in        = bar_ff;
      next_bar_in   = next_bar_ff;
      end_in        = end_ff;
      height_in     = height_ff;
      any_in        = any_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_bar_in    = rsp_bar_ff;
      rsp_height_in = rsp_height_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_redraw_in = rsp_redraw_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_frame_in  = rsp_frame_ff;
      mem_we        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               bar_in      = head.bar_idx;
               next_bar_in = head.fill_from;
               end_in      = head.frame_end;
               state_in    = head.bar_valid ? ST_DIV : ST_NEXT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               height_in = avg_h;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               mem_we        = 1'b1;
               valid_in[idx] = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_bar_in    = bar_ff;
               rsp_height_in = height_ff;
               rsp_peak_in   = new_peak;
               rsp_redraw_in = redraw;
               rsp_last_in   = is_last;
               rsp_frame_in  = is_last & (any_ff | redraw);
               any_in        = any_ff | redraw;
               next_bar_in   = bar_ff + BP_W'(1);
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (end_ff && (next_bar_ff < BP_W'(BARS))) begin
               bar_in    = next_bar_ff;
               height_in = fill_h;
               state_in  = ST_READ;
            end else begin
               if (end_ff) begin
                  any_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         any_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         any_ff       <= any_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_ff        <= bar_in;
      next_bar_ff   <= next_bar_in;
      end_ff        <= end_in;
      height_ff     <= height_in;
      rsp_bar_ff    <= rsp_bar_in;
      rsp_height_ff <= rsp_height_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_redraw_ff <= rsp_redraw_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bar_mem[idx] <= {new_shown, new_speed, new_peak};
      end
      rd_data_ff  <= bar_mem[idx];
      rd_valid_ff <= valid_ff[idx];
   end

   assign bar_ext    = 32'(rsp_bar_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_frame_ff, rsp_redraw_ff, rsp_peak_ff, rsp_height_ff,
                        bar_ext[INDEX_W-1:0]};

   a_peak_above_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_peak_ff >= rsp_height_ff))
      else $error("peak below bar height");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_height_ff <= Q_ONE))
      else $error("bar height above one");

   a_frame_flag_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_ff) |-> rsp_last_ff)
      else $error("frame redraw flag off the last bar");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

endmodule

// ===== rtl/spectrum_bar_peak_hold_meter.sv =====
// Spectrum bar peak-hold meter: top level with register block and queue.
// Depends on sbm_pkg, sbm_front, sbm_queue, sbm_div and sbm_back.
//
// Input beats on req_* carry one spectrum bin each; frames of spectrum_length
// bins are grouped into BARS bars. Each finished bar yields one beat on rsp_*
// with its height, peak, redraw flags and tlast on the final bar of a frame.
// A frame shorter than BARS bins yields the missing bars, at floor level, right
// after its last bin.
// The beat that completes a bar pushes a command into the queue; the back
// pops it and runs the divider (SUM_W = 16 + bits of the largest group, 23 by
// default, one divider bit per cycle), then the read and update states put
// the result in the rsp_* register. Each filled bar passes the next, read and
// update states. The front accepts a bin per cycle while the two-entry command
// queue has room; the back handles one command at a time.
// A stalled rsp_tready holds the result register; the back waits, the queue
// fills, and req_tready then drops.
// Reset restores the register defaults, empties the queue and sets every peak
// and shown height to the default floor and every fall speed to zero.
module spectrum_bar_peak_hold_meter
   import sbm_pkg::*;
#(
   parameter int BARS         = 16,
   parameter int MAX_SPECTRUM = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BIN_W-1:0]      req_tdata,    // [15:0] bin_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] bar_index, [19:4] bar_height, [35:20] peak_level,
   // [36] height_redrawn, [37] frame_redrawn, [39:38] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,    // last_bar
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LEN_MAX = (MAX_SPECTRUM < 2047) ? MAX_SPECTRUM : 2047;
   localparam int PMAX    = (LEN_MAX / BARS > 0) ? LEN_MAX / BARS : 1;
   localparam int P_W     = $clog2(PMAX + 1);
   localparam int SUM_W   = BIN_W + P_W;
   localparam int BP_W    = $clog2(BARS + 1);
   localparam int FP_W    = $clog2(LEN_MAX);
   localparam int CMD_W   = 2 + 2 * BP_W + P_W + SUM_W;

   typedef enum logic [1:0] {
      REG_LENGTH    = 2'd0,
      REG_GRAVITY   = 2'd1,
      REG_FLOOR     = 2'd2,
      REG_THRESHOLD = 2'd3
   } reg_index_type;

   logic [LEN_W-1:0]   len_ff;
   logic [GRAV_W-1:0]  grav_ff;
   logic [LEVEL_W-1:0] floor_ff;
   logic [LEVEL_W-1:0] thr_ff;
   reg_index_type      reg_index;
   logic               csr_write;

   logic               cmd_push;
   logic [CMD_W-1:0]   cmd_data;
   logic               cmd_full;
   logic               cmd_pop;
   logic               cmd_valid;
   logic [CMD_W-1:0]   cmd_head;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_RESET;
         grav_ff  <= GRAV_RESET;
         floor_ff <= LEVEL_RESET;
         thr_ff   <= THR_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_LENGTH:    len_ff   <= csr_pwdata[LEN_W-1:0];
            REG_GRAVITY:   grav_ff  <= csr_pwdata[GRAV_W-1:0];
            REG_FLOOR:     floor_ff <= csr_pwdata[LEVEL_W-1:0];
            REG_THRESHOLD: thr_ff   <= csr_pwdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LENGTH:    csr_prdata = CSR_DATA_W'(len_ff);
         REG_GRAVITY:   csr_prdata = CSR_DATA_W'(grav_ff);
         REG_FLOOR:     csr_prdata = CSR_DATA_W'(floor_ff);
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         default:       csr_prdata = '0;
      endcase
   end

   sbm_front #(
      .BARS    (BARS),
      .LEN_MAX (LEN_MAX),
      .BP_W    (BP_W),
      .P_W     (P_W),
      .SUM_W   (SUM_W),
      .FP_W    (FP_W),
      .CMD_W   (CMD_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .bin_value       (req_tdata),
      .spectrum_length (len_ff),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_data),
      .cmd_full        (cmd_full)
   );

   sbm_queue #(
      .W (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   sbm_back #(
      .BARS  (BARS),
      .BP_W  (BP_W),
      .P_W   (P_W),
      .SUM_W (SUM_W),
      .CMD_W (CMD_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop),
      .gravity_step     (grav_ff),
      .floor_level      (floor_ff),
      .change_threshold (thr_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

endmodule
